// ===== design/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg: shared constants for the quaternion to rotation matrix pipeline
// Lane numbering follows the row-major order of the 3x3 matrix.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int NumLanes = 9;
  localparam int LaneR00  = 0;
  localparam int LaneR01  = 1;
  localparam int LaneR02  = 2;
  localparam int LaneR10  = 3;
  localparam int LaneR11  = 4;
  localparam int LaneR12  = 5;
  localparam int LaneR20  = 6;
  localparam int LaneR21  = 7;
  localparam int LaneR22  = 8;

endpackage

// ===== design/quaternion_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix: quaternion to 3x3 rotation matrix
// Products and sums are registered in qrm_front, the division chain develops
// the quotient bits, and an output register holds the result.
// Throughput one quaternion per cycle; the whole pipe holds only while a
// result waits at the output. Reset clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // q_x, q_y, q_z, q_w from the lowest bit up, zero padded to bytes
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from the lowest bit up
  output logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  // zero_quaternion
  output logic                                      m_axis_tuser
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int RW  = 2 * CW + 1;
  localparam int QW  = F + 2;
  localparam logic [QW-1:0] One = QW'(1) << F;

  logic en;
  logic out_v_q;

  logic                dv   [QW+1];
  logic                dz   [QW+1];
  logic [RW-1:0]       dn   [QW+1];
  logic [NumLanes-1:0] dneg [QW+1];
  logic [RW-1:0]       drem [QW+1][NumLanes];
  logic [QW-1:0]       dquo [QW+1][NumLanes];

  logic [QW:0]    qp1 [NumLanes];
  logic [QW-1:0]  rnd [NumLanes];
  logic [CW-1:0]  res [NumLanes];
  logic [CW-1:0]  out_q [NumLanes];
  logic           out_z_q;

  // Advance everything unless a finished result is being held.
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  qrm_front #(
    .CW(CW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x_i     (s_axis_tdata[0*CW +: CW]),
    .y_i     (s_axis_tdata[1*CW +: CW]),
    .z_i     (s_axis_tdata[2*CW +: CW]),
    .w_i     (s_axis_tdata[3*CW +: CW]),
    .valid_o (dv[0]),
    .zero_o  (dz[0]),
    .n_o     (dn[0]),
    .neg_o   (dneg[0]),
    .mag_o   (drem[0])
  );

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      dquo[0][i] = '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    qrm_div_stage #(
      .RW    (RW),
      .QW    (QW),
      .FIRST (s == 0)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[s]),
      .zero_i  (dz[s]),
      .n_i     (dn[s]),
      .neg_i   (dneg[s]),
      .rem_i   (drem[s]),
      .quo_i   (dquo[s]),
      .valid_o (dv[s+1]),
      .zero_o  (dz[s+1]),
      .n_o     (dn[s+1]),
      .neg_o   (dneg[s+1]),
      .rem_o   (drem[s+1]),
      .quo_o   (dquo[s+1])
    );
  end

  // Quotient carries one extra bit: add half and drop it to round, ties away.
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      qp1[i] = {1'b0, dquo[QW][i]} + (QW+1)'(1);
      rnd[i] = (qp1[i][QW:1] > One) ? One : qp1[i][QW:1];
      if (dz[QW]) begin
        res[i] = (i == LaneR00 || i == LaneR11 || i == LaneR22) ? CW'(One) : '0;
      end else begin
        res[i] = dneg[QW][i] ? -CW'(rnd[i]) : CW'(rnd[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q   <= res;
      out_z_q <= dz[QW];
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < NumLanes; i++) begin
      m_axis_tdata[i*CW +: CW] = out_q[i];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_z_q;

`ifndef NO_ASSERTIONS
  a_zero_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (out_q[LaneR00] == CW'(One) && out_q[LaneR11] == CW'(One) &&
       out_q[LaneR22] == CW'(One) && out_q[LaneR01] == '0))
    else $error("zero quaternion did not give the identity");

  a_diag_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(out_q[LaneR00]) <= $signed(CW'(One)) &&
                       $signed(out_q[LaneR00]) >= -$signed(CW'(One))))
    else $error("matrix entry beyond unit range");

  a_stall_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(out_q[LaneR01])))
    else $error("stalled result changed");
`endif

endmodule

// ===== design/qrm_front.sv =====
// ----------------------------------------------------------------------------
// qrm_front: products and numerator sums
// Stage A forms the ten component products, stage B the squared norm and
// the sign and magnitude of the nine numerators.
// ----------------------------------------------------------------------------
module qrm_front
  import qrm_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  input  logic signed [CW-1:0] w_i,
  output logic                 valid_o,
  output logic                 zero_o,
  output logic [2*CW:0]        n_o,
  output logic [NumLanes-1:0]  neg_o,
  output logic [2*CW:0]        mag_o [NumLanes]
);

  localparam int PW = 2 * CW;
  localparam int NW = 2 * CW + 2;

  logic signed [PW-1:0] xe, ye, ze, we;
  logic signed [PW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic                 va_q;

  logic signed [NW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  logic signed [NW-1:0] num [NumLanes];
  logic signed [NW-1:0] nsum;
  logic                 vb_q;

  assign xe = PW'(x_i);
  assign ye = PW'(y_i);
  assign ze = PW'(z_i);
  assign we = PW'(w_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= xe * xe;
      yy_q <= ye * ye;
      zz_q <= ze * ze;
      ww_q <= we * we;
      xy_q <= xe * ye;
      xz_q <= xe * ze;
      yz_q <= ye * ze;
      wx_q <= we * xe;
      wy_q <= we * ye;
      wz_q <= we * ze;
    end
  end

  assign xx = NW'(xx_q);
  assign yy = NW'(yy_q);
  assign zz = NW'(zz_q);
  assign ww = NW'(ww_q);
  assign xy = NW'(xy_q);
  assign xz = NW'(xz_q);
  assign yz = NW'(yz_q);
  assign wx = NW'(wx_q);
  assign wy = NW'(wy_q);
  assign wz = NW'(wz_q);

  // Every numerator is bounded by the squared norm in magnitude.
  always_comb begin
    nsum          = xx + yy + zz + ww;
    num[LaneR00]  = xx + ww - yy - zz;
    num[LaneR01]  = (xy + wz) <<< 1;
    num[LaneR02]  = (xz - wy) <<< 1;
    num[LaneR10]  = (xy - wz) <<< 1;
    num[LaneR11]  = yy + ww - xx - zz;
    num[LaneR12]  = (yz + wx) <<< 1;
    num[LaneR20]  = (xz + wy) <<< 1;
    num[LaneR21]  = (yz - wx) <<< 1;
    num[LaneR22]  = zz + ww - xx - yy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o    <= nsum[2*CW:0];
      zero_o <= (nsum == '0);
      for (int i = 0; i < NumLanes; i++) begin
        neg_o[i] <= num[i][NW-1];
        mag_o[i] <= num[i][NW-1] ? (2*CW+1)'(-num[i]) : num[i][2*CW:0];
      end
    end
  end

  assign valid_o = vb_q;

endmodule

// ===== design/qrm_div_stage.sv =====
// ----------------------------------------------------------------------------
// qrm_div_stage: one restoring division step for all nine lanes
// Develops one quotient bit per lane against the shared squared norm.
// ----------------------------------------------------------------------------
module qrm_div_stage
  import qrm_pkg::*;
#(
  parameter int RW    = 33,
  parameter int QW    = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                zero_i,
  input  logic [RW-1:0]       n_i,
  input  logic [NumLanes-1:0] neg_i,
  input  logic [RW-1:0]       rem_i [NumLanes],
  input  logic [QW-1:0]       quo_i [NumLanes],
  output logic                valid_o,
  output logic                zero_o,
  output logic [RW-1:0]       n_o,
  output logic [NumLanes-1:0] neg_o,
  output logic [RW-1:0]       rem_o [NumLanes],
  output logic [QW-1:0]       quo_o [NumLanes]
);

  logic [RW:0]     trial [NumLanes];
  logic [RW:0]     diff  [NumLanes];
  logic [NumLanes-1:0] ge;

  // The first step takes the integer bit, later ones shift the remainder.
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      trial[i] = FIRST ? {1'b0, rem_i[i]} : {rem_i[i], 1'b0};
      diff[i]  = trial[i] - {1'b0, n_i};
      ge[i]    = (trial[i] >= {1'b0, n_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_o <= zero_i;
      n_o    <= n_i;
      neg_o  <= neg_i;
      for (int i = 0; i < NumLanes; i++) begin
        rem_o[i] <= ge[i] ? diff[i][RW-1:0] : trial[i][RW-1:0];
        quo_o[i] <= {quo_i[i][QW-2:0], ge[i]};
      end
    end
  end

endmodule

// ===== dv/qrm_checker.sv =====
// ----------------------------------------------------------------------------
// qrm_checker: scoreboard for the quaternion to rotation matrix pipeline
// Predicts the nine matrix entries and the zero flag of every accepted
// quaternion and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module qrm_checker
  import qrm_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // q_x, q_y, q_z, q_w from the lowest bit up
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from the lowest bit up
  input  logic [143:0] m_axis_tdata,
  // zero_quaternion
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic         zero_q;
    logic [143:0] entries;
  } matrix_t;

  matrix_t matrix_q[$];
  int      fails = 0;

  localparam longint One = longint'(1) << FRACTION_BITS;

  function automatic longint round_ratio(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << (FRACTION_BITS + 1)) + den) / (den << 1);
    if (q > One) q = One;
    return (num < 0) ? -q : q;
  endfunction

  function automatic matrix_t rotation_of(logic [63:0] d);
    longint x, y, z, w, n;
    longint m[NumLanes];
    matrix_t r;
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    z = longint'($signed(d[47:32]));
    w = longint'($signed(d[63:48]));
    n = x*x + y*y + z*z + w*w;
    if (n == 0) begin
      foreach (m[k]) m[k] = 0;
      m[LaneR00] = One;
      m[LaneR11] = One;
      m[LaneR22] = One;
    end else begin
      m[LaneR00] = round_ratio(x*x + w*w - y*y - z*z, n);
      m[LaneR01] = round_ratio(2*(x*y + w*z), n);
      m[LaneR02] = round_ratio(2*(x*z - w*y), n);
      m[LaneR10] = round_ratio(2*(x*y - w*z), n);
      m[LaneR11] = round_ratio(y*y + w*w - x*x - z*z, n);
      m[LaneR12] = round_ratio(2*(y*z + w*x), n);
      m[LaneR20] = round_ratio(2*(x*z + w*y), n);
      m[LaneR21] = round_ratio(2*(y*z - w*x), n);
      m[LaneR22] = round_ratio(z*z + w*w - x*x - y*y, n);
    end
    foreach (m[k]) r.entries[k*16 +: 16] = m[k][15:0];
    r.zero_q = (n == 0);
    return r;
  endfunction

  assign fail_count_o = fails;

  always @(posedge clk_i) begin
    matrix_t exp_m;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) matrix_q.push_back(rotation_of(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected output transfer %h", $time, m_axis_tdata);
          fails = fails + 1;
        end else begin
          exp_m = matrix_q.pop_front();
          for (int k = 0; k < NumLanes; k++) begin
            if (m_axis_tdata[k*16 +: 16] !== exp_m.entries[k*16 +: 16]) begin
              $display("%0t: entry %0d expected %0d actual %0d", $time, k,
                       $signed(exp_m.entries[k*16 +: 16]),
                       $signed(m_axis_tdata[k*16 +: 16]));
              fails = fails + 1;
            end
          end
          if (m_axis_tuser !== exp_m.zero_q) begin
            $display("%0t: zero flag expected %b actual %b", $time, exp_m.zero_q,
                     m_axis_tuser);
            fails = fails + 1;
          end
        end
      end
    end
    pending_o = matrix_q.size();
  end

endmodule

// ===== dv/quaternion_to_rotation_matrix_test.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_test: stimulus and verdict
// Sends directed corner quaternions, then random ones of mixed magnitude,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_test;

  localparam int RandomItems  = 750;
  localparam int IdleLimit    = 2000;
  localparam int DrainCycles  = 40;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  bit           sending_done = 1'b0;

  always #5 clk_i = ~clk_i;

  quaternion_to_rotation_matrix uut (.*);

  qrm_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  function automatic logic [15:0] rand_component();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32767)) - 16384);
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  task automatic send_quaternion(logic [15:0] x, y, z, w);
    repeat (($urandom_range(0, 3) == 0) ? gap_len() : 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stall the output at random, drawing tready anew on each falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni && (!sending_done || pending != 0))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quaternion(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quaternion(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quaternion(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quaternion(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quaternion(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quaternion(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    send_quaternion(16'h2d41, 16'h0000, 16'h0000, 16'h2d41);
    send_quaternion(16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_quaternion(16'h0001, 16'h0001, 16'h0000, 16'h0000);
    send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_quaternion(16'h0003, 16'hfffd, 16'h0001, 16'h0002);
    send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (RandomItems) begin
      if ($urandom_range(0, 49) == 0)
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      else
        send_quaternion(rand_component(), rand_component(), rand_component(),
                        rand_component());
      // Burst back to back now and then by keeping tvalid high.
      if ($urandom_range(0, 2) == 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/qrm_pkg.sv
design/qrm_front.sv
design/qrm_div_stage.sv
design/quaternion_to_rotation_matrix.sv
dv/qrm_checker.sv
dv/quaternion_to_rotation_matrix_test.sv
